// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared types and codes of the first-fit fixed-partition allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned MemW  = 20;
  localparam int unsigned SizeW = 16;
  localparam int unsigned PidW  = 6;

  // actions
  localparam logic [1:0] ACT_DEFINE = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // status codes
  localparam logic [3:0] ST_ACCEPT   = 4'd0;
  localparam logic [3:0] ST_REJECT   = 4'd1;
  localparam logic [3:0] ST_PLACED   = 4'd2;
  localparam logic [3:0] ST_TOOLARGE = 4'd3;
  localparam logic [3:0] ST_EXISTS   = 4'd4;
  localparam logic [3:0] ST_NOSPACE  = 4'd5;
  localparam logic [3:0] ST_INTFRAG  = 4'd6;
  localparam logic [3:0] ST_EXTFRAG  = 4'd7;
  localparam logic [3:0] ST_REMOVED  = 4'd8;
  localparam logic [3:0] ST_ABSENT   = 4'd9;
  localparam logic [3:0] ST_FULL     = 4'd10;

  // controller to datapath
  typedef struct packed {
    logic latch_in;     // capture input item
    logic do_define;    // commit define
    logic scan_clr;     // scan index to zero
    logic scan_inc;     // advance scan index
    logic place;        // place process at scan index
    logic do_delete;    // free process
    logic set_result;   // load result register
    logic [3:0] status; // status for result
    logic idx_scan;     // result index from scan index
    logic idx_proc;     // result index from proc table
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       table_full;
    logic       too_large;
    logic       id_out;
    logic       present;
    logic       no_space;
    logic       def_ok;
    logic       scan_done;  // scan index past last partition
    logic       fit_hit;    // current entry is empty and fits
    logic       frag_hit;   // current entry slack fits
  } ffpa_stat_t;

endpackage

// ===== sv/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl
// sequencer: decodes the action and steps the first-fit and slack scans
// ----------------------------------------------------------------------------
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  output logic       busy,
  input  logic       out_free,   // result register empty or being taken
  input  ffpa_stat_t stat,
  output ffpa_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_FIT    = 3'd2;
  localparam logic [2:0] S_PRE    = 3'd3;
  localparam logic [2:0] S_FRAG   = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_FWAIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_fire;
        if (in_fire) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!out_free) begin
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_IDLE;
          unique case (stat.action)
            ACT_DEFINE: begin
              cmd.set_result = 1'b1;
              cmd.idx_scan   = 1'b0;
              if (stat.table_full) cmd.status = ST_FULL;
              else begin
                cmd.do_define = 1'b1;
                cmd.status = stat.def_ok ? ST_ACCEPT : ST_REJECT;
              end
            end
            ACT_INSERT: begin
              priority if (stat.too_large) begin
                cmd.set_result = 1'b1; cmd.status = ST_TOOLARGE;
              end else if (stat.id_out) begin
                cmd.set_result = 1'b1; cmd.status = ST_NOSPACE;
              end else if (stat.present) begin
                cmd.set_result = 1'b1; cmd.status = ST_EXISTS; cmd.idx_proc = 1'b1;
              end else if (stat.no_space) begin
                cmd.set_result = 1'b1; cmd.status = ST_NOSPACE;
              end else begin
                cmd.scan_clr = 1'b1;
                state_nxt = S_FWAIT;
              end
            end
            ACT_DELETE: begin
              cmd.set_result = 1'b1;
              if (stat.id_out || !stat.present) cmd.status = ST_ABSENT;
              else begin
                cmd.do_delete = 1'b1; cmd.status = ST_REMOVED; cmd.idx_proc = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FWAIT: state_nxt = S_FIT;  // wait for the registered partition size read
      S_FIT: begin
        priority if (stat.scan_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt = S_PRE;
        end else if (stat.fit_hit) begin
          cmd.place = 1'b1; cmd.set_result = 1'b1;
          cmd.status = ST_PLACED; cmd.idx_scan = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt = S_FWAIT;
        end
      end
      S_PRE: state_nxt = S_FRAG;  // wait for the registered held-size read
      S_FRAG: begin
        priority if (stat.scan_done) begin
          cmd.set_result = 1'b1; cmd.status = ST_EXTFRAG;
          state_nxt = S_IDLE;
        end else if (stat.frag_hit) begin
          cmd.set_result = 1'b1; cmd.status = ST_INTFRAG;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_FRAG;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/ffpa_dp.sv =====
// ----------------------------------------------------------------------------
// ffpa_dp
// partition and process tables, totals and result register
// ----------------------------------------------------------------------------
module ffpa_dp import ffpa_pkg::*; #(
  parameter int unsigned PART_SLOTS = 64,
  parameter int unsigned PROC_SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MemW-1:0]  total_memory,
  input  logic [1:0]       in_action,
  input  logic [PidW-1:0]  in_pid,
  input  logic [SizeW-1:0] in_size,
  input  ffpa_cmd_t        cmd,
  output ffpa_stat_t       stat,
  input  logic             out_take,
  output logic             out_valid,
  output logic             out_free,
  output logic [3:0]       out_status,
  output logic [PidW-1:0]  out_index,
  output logic [MemW-1:0]  out_remaining,
  output logic [MemW-1:0]  out_unused
);

  localparam int unsigned PaW = (PART_SLOTS > 1) ? $clog2(PART_SLOTS) : 1;
  localparam int unsigned PrW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
  localparam int unsigned PcW = $clog2(PART_SLOTS + 1);

  // memories
  logic [SizeW-1:0] part_size_m [PART_SLOTS];
  logic [SizeW-1:0] part_held_m [PART_SLOTS];  // size of the resident process
  logic [SizeW-1:0] proc_size_m [PROC_SLOTS];
  logic [PaW-1:0]   proc_part_m [PROC_SLOTS];
  // flag vectors
  logic [PART_SLOTS-1:0] part_valid_r, part_busy_r;
  logic [PROC_SLOTS-1:0] proc_present_r;

  logic [PcW-1:0]   part_count_r;
  logic [MemW-1:0]  psum_r, used_r;
  logic [SizeW-1:0] largest_r;
  logic [1:0]       act_r;
  logic [PidW-1:0]  pid_r;
  logic [SizeW-1:0] size_r;
  logic [PcW-1:0]   scan_r;
  logic [SizeW-1:0] held_r, psz_r;
  logic             own_r;

  logic [MemW-1:0] remaining, unused;
  logic [PrW-1:0]  pid_idx, rd_pid;
  logic [PaW-1:0]  scan_idx, cnt_idx;
  logic            pid_in;

  assign remaining = (total_memory >= psum_r) ? total_memory - psum_r : '0;
  assign unused    = (psum_r >= used_r) ? psum_r - used_r : '0;
  assign pid_idx   = PrW'(pid_r);
  assign rd_pid    = cmd.latch_in ? PrW'(in_pid) : pid_idx;
  assign pid_in    = (PidW'(pid_r) < PidW'(PROC_SLOTS)) || (PROC_SLOTS >= 64);
  assign scan_idx  = scan_r[PaW-1:0];
  assign cnt_idx   = part_count_r[PaW-1:0];

  always_comb begin
    stat.action     = act_r;
    stat.table_full = (part_count_r == PcW'(PART_SLOTS));
    stat.too_large  = (size_r > largest_r);
    stat.id_out     = !pid_in;
    stat.present    = pid_in && proc_present_r[pid_idx];
    stat.no_space   = (MemW'(size_r) > unused);
    stat.def_ok     = (MemW'(size_r) <= remaining);
    stat.scan_done  = (scan_r >= part_count_r);
    stat.fit_hit    = part_valid_r[scan_idx] && !part_busy_r[scan_idx]
                      && (size_r <= psz_r);
    stat.frag_hit   = own_r && (psz_r >= held_r)
                      && ((psz_r - held_r) >= size_r);
  end

  // tables: sizes and proc slot info
  always_ff @(posedge clk) begin
    if (cmd.do_define && !stat.table_full) part_size_m[cnt_idx] <= size_r;
    if (cmd.place) begin
      proc_size_m[pid_idx] <= size_r;
      proc_part_m[pid_idx] <= scan_idx;
      part_held_m[scan_idx] <= size_r;
    end
    // registered reads for both scans
    held_r <= part_held_m[scan_idx];
    psz_r  <= part_size_m[scan_idx];
    own_r  <= part_busy_r[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_action; pid_r <= in_pid; size_r <= in_size;
    end
    if (cmd.scan_clr)      scan_r <= '0;
    else if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
  end

  // process entry read, addressed by the incoming item while it is taken
  logic [SizeW-1:0] del_size;
  logic [PaW-1:0]   del_part;
  always_ff @(posedge clk) begin
    del_size <= proc_size_m[rd_pid];
    del_part <= proc_part_m[rd_pid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_valid_r   <= '0;
      part_busy_r    <= '0;
      proc_present_r <= '0;
      part_count_r   <= '0;
      psum_r         <= '0;
      used_r         <= '0;
      largest_r      <= '0;
    end else begin
      if (cmd.do_define) begin
        part_count_r <= part_count_r + 1'b1;
        part_busy_r[cnt_idx]  <= 1'b0;
        part_valid_r[cnt_idx] <= stat.def_ok;
        if (stat.def_ok) begin
          psum_r <= psum_r + MemW'(size_r);
          if (size_r > largest_r) largest_r <= size_r;
        end
      end
      if (cmd.place) begin
        part_busy_r[scan_idx]   <= 1'b1;
        proc_present_r[pid_idx] <= 1'b1;
        used_r <= used_r + MemW'(size_r);
      end
      if (cmd.do_delete) begin
        part_busy_r[del_part]   <= 1'b0;
        proc_present_r[pid_idx] <= 1'b0;
        used_r <= (used_r >= MemW'(del_size)) ? used_r - MemW'(del_size) : '0;
      end
    end
  end

  // result register; totals are post-action and captured in the cycle after the status
  logic res_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid  <= 1'b0;
      res_pend_r <= 1'b0;
    end else begin
      res_pend_r <= cmd.set_result;
      if (res_pend_r)    out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      out_status <= cmd.status;
      if (cmd.idx_scan)      out_index <= PidW'(scan_idx);
      else if (cmd.idx_proc) out_index <= PidW'(del_part);
      else if (cmd.status == ST_ACCEPT || cmd.status == ST_REJECT)
        out_index <= PidW'(cnt_idx);
      else                   out_index <= '0;
    end
    if (res_pend_r) begin
      out_remaining <= remaining;
      out_unused    <= unused;
    end
  end

  assign out_free = !res_pend_r && (!out_valid || out_take);

endmodule

// ===== sv/first_fit_fixed_partition_alloc_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_fixed_partition_alloc_top
// fixed-partition allocator with first-fit placement
// ----------------------------------------------------------------------------
// one item at a time: after an item is taken the block decodes it (waiting
// while the result register is not free); define, delete and every refused
// insert then return to ready, the result valid once set_result and res_pend_r
// are registered; an insert that scans walks the partitions first-fit and then
// for slack, each step waiting on registered reads of the size tables; no
// clearing pass after reset
module first_fit_fixed_partition_alloc_top import ffpa_pkg::*; #(
  parameter int unsigned PART_SLOTS = 64,
  parameter int unsigned PROC_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,        // total_memory [19:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,        // action [1:0], process_id [7:2], request_size [23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata        // status [3:0], partition_index [9:4],
                                       // remaining_memory [29:10], unused_space [49:30]
);

  logic [MemW-1:0] total_r;
  ffpa_cmd_t  cmd;
  ffpa_stat_t stat;
  logic busy, out_free, in_fire, nop;
  logic [3:0]      st;
  logic [PidW-1:0] idx;
  logic [MemW-1:0] rem, unu;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)         total_r <= '0;
    else if (cfg_valid) total_r <= cfg_data[MemW-1:0];
  end

  // no-operation items are taken and dropped
  assign in_tready = !busy;
  assign nop       = (in_tdata[1:0] == ACT_NOP);
  assign in_fire   = in_tvalid && !busy && !nop;

  ffpa_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .busy, .out_free, .stat, .cmd
  );

  ffpa_dp #(.PART_SLOTS(PART_SLOTS), .PROC_SLOTS(PROC_SLOTS)) u_dp (
    .clk, .rst_n,
    .total_memory (total_r),
    .in_action    (in_tdata[1:0]),
    .in_pid       (in_tdata[7:2]),
    .in_size      (in_tdata[23:8]),
    .cmd, .stat,
    .out_take     (out_tready),
    .out_valid    (out_tvalid),
    .out_free,
    .out_status   (st),
    .out_index    (idx),
    .out_remaining(rem),
    .out_unused   (unu)
  );

  assign out_tdata = {6'd0, unu, rem, idx, st};

endmodule

// ===== dv/tb_first_fit_fixed_partition_alloc_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_fixed_partition_alloc_top
// self-checking bench for the first-fit fixed-partition allocator
// ----------------------------------------------------------------------------
// a behavioral allocator model predicts each result; a queue-fed driver sends
// define, insert, delete and no-op items with random gaps, a monitor with
// random back-pressure compares every result field by field
module tb_first_fit_fixed_partition_alloc_top;
  import ffpa_pkg::*;

  localparam int NPART = 64;
  localparam int NPROC = 64;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [19:0] unused;
    logic [19:0] remain;
    logic [5:0]  pidx;
    logic [3:0]  status;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  first_fit_fixed_partition_alloc_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state of the allocator
  logic [19:0] mem_total;
  logic [15:0] part_sz [NPART];
  logic        part_ok [NPART];
  int          part_own [NPART];   // -1 when empty
  int          n_parts;
  logic [19:0] carved_sum;
  logic [15:0] biggest;
  logic [19:0] held_sum;
  logic [15:0] pr_sz [NPROC];
  logic [5:0]  pr_part [NPROC];
  logic        pr_live [NPROC];

  logic [23:0] item_q [$];
  alloc_res_t  result_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;       // no idling in the last part of the run
  bit          stim_done = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  logic        in_tready_s = 1'b0;

  function automatic logic [19:0] remain_now();
    return (mem_total >= carved_sum) ? mem_total - carved_sum : 20'd0;
  endfunction

  function automatic logic [19:0] unused_now();
    return (carved_sum >= held_sum) ? carved_sum - held_sum : 20'd0;
  endfunction

  task automatic model_reset();
    mem_total = '0;
    for (int i = 0; i < NPART; i++) begin
      part_sz[i] = '0; part_ok[i] = 1'b0; part_own[i] = -1;
    end
    for (int i = 0; i < NPROC; i++) begin
      pr_sz[i] = '0; pr_part[i] = '0; pr_live[i] = 1'b0;
    end
    n_parts = 0; carved_sum = '0; biggest = '0; held_sum = '0;
  endtask

  // apply one item to the model and queue the result it produces
  task automatic predict_alloc(input logic [23:0] it);
    logic [1:0]  act;
    logic [5:0]  pid;
    logic [15:0] sz;
    alloc_res_t  r;
    bit          done;
    act = it[1:0];
    pid = it[7:2];
    sz = it[23:8];
    r = '0;
    done = 1'b0;
    if (act == ACT_NOP) return;
    case (act)
      ACT_DEFINE: begin
        if (n_parts >= NPART) r.status = ST_FULL;
        else begin
          r.pidx = n_parts[5:0];
          part_sz[n_parts] = sz;
          part_own[n_parts] = -1;
          if ({4'd0, sz} <= remain_now()) begin
            part_ok[n_parts] = 1'b1;
            carved_sum = carved_sum + sz;
            if (sz > biggest) biggest = sz;
            r.status = ST_ACCEPT;
          end else begin
            part_ok[n_parts] = 1'b0;
            r.status = ST_REJECT;
          end
          n_parts++;
        end
      end
      ACT_INSERT: begin
        if (sz > biggest) r.status = ST_TOOLARGE;
        else if (pr_live[pid]) begin
          r.status = ST_EXISTS; r.pidx = pr_part[pid];
        end else if ({4'd0, sz} > unused_now()) r.status = ST_NOSPACE;
        else begin
          for (int i = 0; i < n_parts && !done; i++)
            if (part_ok[i] && part_own[i] < 0 && sz <= part_sz[i]) begin
              part_own[i] = pid; pr_part[pid] = i[5:0]; pr_sz[pid] = sz;
              pr_live[pid] = 1'b1; held_sum = held_sum + sz;
              r.status = ST_PLACED; r.pidx = i[5:0]; done = 1'b1;
            end
          if (!done) begin
            r.status = ST_EXTFRAG;
            for (int i = 0; i < n_parts; i++)
              if (part_own[i] >= 0 && part_sz[i] >= pr_sz[part_own[i]] &&
                  part_sz[i] - pr_sz[part_own[i]] >= sz)
                r.status = ST_INTFRAG;
          end
        end
      end
      default: begin
        if (!pr_live[pid]) r.status = ST_ABSENT;
        else begin
          part_own[pr_part[pid]] = -1;
          held_sum = (held_sum >= pr_sz[pid]) ? held_sum - pr_sz[pid] : 20'd0;
          pr_live[pid] = 1'b0;
          r.status = ST_REMOVED; r.pidx = pr_part[pid];
        end
      end
    endcase
    r.remain = remain_now();
    r.unused = unused_now();
    result_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [23:0] mk_item(logic [1:0] a, logic [5:0] p, logic [15:0] s);
    return {s, p, a};
  endfunction

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_s) begin
        predict_alloc(in_tdata);
        void'(item_q.pop_front());
      end
      if (!(in_tvalid && !in_tready_s)) begin
        if (in_gap > 0) begin
          in_gap--; in_tvalid <= 1'b0;
        end else if (item_q.size() > 0) begin
          in_tvalid <= 1'b1; in_tdata <= item_q[0];
          if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 3);
        end else in_tvalid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--; out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 3);
      end
    end
  end

  // handshakes sampled at the rising edge
  always @(posedge clk) begin
    in_tready_s <= in_tready && in_tvalid ? 1'b1 : 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    alloc_res_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[49:0];
      if (result_q.size() == 0) report_mismatch("unexpected result", got.status, -1);
      else begin
        want = result_q.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.pidx !== want.pidx) report_mismatch("partition_index", got.pidx, want.pidx);
        if (got.remain !== want.remain) report_mismatch("remaining", got.remain, want.remain);
        if (got.unused !== want.unused) report_mismatch("unused", got.unused, want.unused);
      end
    end
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (item_q.size() > 0 || in_tvalid) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_total(input logic [19:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_data <= {4'd0, v};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mem_total = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a random phase: a random mix of defines, inserts, deletes and no-ops, mostly insert/delete traffic
  task automatic random_phase(input int n, input int max_sz);
    logic [1:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    a = ACT_DEFINE;
        2, 3, 4, 5: a = ACT_INSERT;
        6, 7, 8: a = ACT_DELETE;
        default: a = ACT_NOP;
      endcase
      item_q.push_back(mk_item(a, 6'($urandom_range(0, 63)),
        ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, max_sz))));
    end
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: zero total, then a small table with define, insert and delete outcomes
    item_q.push_back(mk_item(ACT_INSERT, 6'd1, 16'd0));     // external, nothing defined
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd0));     // size zero accepted
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd1));     // rejected, takes a slot
    drain();
    write_total(20'd300);
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd100));
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd50));
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd200));   // rejected
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd150));
    item_q.push_back(mk_item(ACT_INSERT, 6'd63, 16'd151));  // too large
    item_q.push_back(mk_item(ACT_INSERT, 6'd0, 16'd0));     // zero size placed
    item_q.push_back(mk_item(ACT_INSERT, 6'd0, 16'd10));    // exists
    item_q.push_back(mk_item(ACT_INSERT, 6'd63, 16'd40));   // placed
    item_q.push_back(mk_item(ACT_INSERT, 6'd5, 16'd140));   // placed
    item_q.push_back(mk_item(ACT_INSERT, 6'd6, 16'd30));    // placed
    item_q.push_back(mk_item(ACT_INSERT, 6'd7, 16'd80));    // external fragmentation
    item_q.push_back(mk_item(ACT_DELETE, 6'd63, 16'hffff)); // removed
    item_q.push_back(mk_item(ACT_DELETE, 6'd63, 16'd0));    // absent
    item_q.push_back(mk_item(ACT_NOP, 6'd42, 16'h5a5a));
    item_q.push_back(mk_item(ACT_INSERT, 6'd8, 16'd60));    // placed
    drain();
    // lowered total below the accepted sum
    write_total(20'd10);
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd1));
    item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'd0));
    drain();
    // maximum total, fill the table to overflow
    write_total(20'hfffff);
    for (int i = 0; i < 70; i++)
      item_q.push_back(mk_item(ACT_DEFINE, 6'd0, 16'($urandom_range(0, 16'hffff))));
    random_phase(300, 16'hffff);
    drain();
    // fresh state needs a reset, so continue on the full table with small sizes
    write_total(20'($urandom_range(0, 20'hfffff)));
    random_phase(350, 2000);
    drain();
    calm = 1'b1;
    write_total(20'd0);
    random_phase(300, 16'hffff);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/ffpa_pkg.sv
sv/ffpa_ctrl.sv
sv/ffpa_dp.sv
sv/first_fit_fixed_partition_alloc_top.sv
dv/tb_first_fit_fixed_partition_alloc_top.sv
